[src/cstrip_pkg.sv]
// cstrip_pkg: word types, character codes and the per-byte decision function
// shared by the comment stripper top level and its checker.
// no dependencies.
package cstrip_pkg;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // output queue depth; two words may arrive from one input word
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] clean_byte;
        logic       clean_end;
    } out_word_t;

    typedef struct packed {
        logic [7:0] held_char;
        logic       held_is_first;
        logic [7:0] prior_output;
        logic       blank_held;
        logic       in_string;
        logic       in_block_comment;
        logic       in_line_comment;
        logic       continuation_pending;
    } scan_state_t;

    typedef struct packed {
        scan_state_t st;
        logic [7:0]  c;
        logic        blank_follower;
    } decide_t;

    localparam scan_state_t SCAN_RESET = '{
        held_char:            8'h00,
        held_is_first:        1'b1,
        prior_output:         8'h00,
        blank_held:           1'b0,
        in_string:            1'b0,
        in_block_comment:     1'b0,
        in_line_comment:      1'b0,
        continuation_pending: 1'b0
    };

    // decide the held byte given its follower (if any)
    function automatic decide_t cstrip_decide(scan_state_t st, logic has_next,
                                              logic [7:0] follower);
        decide_t    r;
        logic [7:0] c;
        logic       in_comment;
        r          = '0;
        r.st       = st;
        c          = st.blank_held ? CH_SPACE : st.held_char;
        in_comment = st.in_block_comment || st.in_line_comment;

        if (c == CH_SLASH && has_next && !st.in_string && !in_comment) begin
            if (follower == CH_STAR) begin
                r.st.in_block_comment = 1'b1;
            end else if (follower == CH_SLASH) begin
                r.st.in_line_comment = 1'b1;
            end
        end else if (c == CH_QUOTE && !st.held_is_first
                     && st.prior_output != CH_BACKSLASH && !in_comment) begin
            r.st.in_string = !st.in_string;
        end else if (c == CH_STAR && has_next && follower == CH_SLASH
                     && st.in_block_comment && !st.in_line_comment
                     && !st.in_string) begin
            r.st.in_block_comment = 1'b0;
            c                     = CH_SPACE;
            r.blank_follower      = 1'b1;
        end else if (c == CH_NEWLINE && !st.held_is_first && st.in_line_comment
                     && !st.continuation_pending && !st.in_block_comment
                     && !st.in_string) begin
            r.st.in_line_comment = 1'b0;
        end else if (c == CH_BACKSLASH && st.in_line_comment
                     && !st.in_block_comment && !st.in_string) begin
            r.st.continuation_pending = 1'b1;
        end else if (c != CH_BACKSLASH && st.continuation_pending) begin
            r.st.continuation_pending = 1'b0;
        end

        if (r.st.in_block_comment || r.st.in_line_comment) begin
            c = CH_SPACE;
        end

        r.st.prior_output  = c;
        r.st.held_is_first = 1'b0;
        r.c                = c;
        return r;
    endfunction

endpackage

[src/c_comment_stripper.sv]
// c_comment_stripper: streaming C/C++ comment blanker, top level.
// depends on cstrip_pkg.

// Takes one source byte per cycle and returns it, or a space where it lies inside a
// slash-star or slash-slash comment. Each byte is decided when its follower arrives,
// so output runs one word behind the input; the word marked text_end flushes the
// held byte, if any, and itself (the last output word has clean_end set) and the
// scanner then returns to its reset state for the next file. The decision is a few
// byte compares on flag registers done at accept time, and results go through a
// four-word output queue, so a new word is accepted every cycle as long as the
// sink takes one per cycle; s_ready drops only while three or more words are queued.
module c_comment_stripper
    import cstrip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    scan_state_t st_reg, st_next;
    logic        held_valid_reg, held_valid_next;

    out_word_t   oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_AW:0]   count_reg;

    logic        s_acc, m_acc;
    decide_t     res0, res1;
    scan_state_t st_mid;
    logic        push0, push1;
    out_word_t   first_word, second_word;
    logic [1:0]  n_push;

    assign s_ready = (count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign s_acc   = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = oq_reg[rd_ptr_reg];
    assign m_acc   = m_valid && m_ready;

    always_comb begin
        res0   = cstrip_decide(st_reg, 1'b1, s_data.text_byte);
        st_mid = held_valid_reg ? res0.st : st_reg;
        st_mid.held_char  = s_data.text_byte;
        st_mid.blank_held = held_valid_reg && res0.blank_follower;
        // flush decision for the last word, no follower
        res1   = cstrip_decide(st_mid, 1'b0, 8'h00);

        push0 = s_acc && held_valid_reg;
        push1 = s_acc && s_data.text_end;
        n_push = {1'b0, push0} + {1'b0, push1};

        first_word  = push0 ? out_word_t'{clean_byte: res0.c, clean_end: 1'b0}
                            : out_word_t'{clean_byte: res1.c, clean_end: 1'b1};
        second_word = '{clean_byte: res1.c, clean_end: 1'b1};

        st_next         = st_reg;
        held_valid_next = held_valid_reg;
        if (s_acc) begin
            if (s_data.text_end) begin
                st_next         = SCAN_RESET;
                held_valid_next = 1'b0;
            end else begin
                st_next         = st_mid;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= SCAN_RESET;
            held_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            st_reg         <= st_next;
            held_valid_reg <= held_valid_next;
            wr_ptr_reg     <= wr_ptr_reg + OQ_AW'(n_push);
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (OQ_AW+1)'(n_push) - (OQ_AW+1)'(m_acc);
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (push0 || push1) begin
            oq_reg[wr_ptr_reg] <= first_word;
        end
        if (push0 && push1) begin
            oq_reg[wr_ptr_reg + 1'b1] <= second_word;
        end
    end

endmodule

[src/cstrip_checker.sv]
// cstrip_checker: port-level assertions for c_comment_stripper, and its bind.
// depends on cstrip_pkg and c_comment_stripper.
module cstrip_checker
    import cstrip_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word shown right after reset");

    // input only backs up while results are waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    // the last word of a file always produces a result
    a_end_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.text_end |=> m_valid)
        else $error("end of file gave no result");

endmodule

bind c_comment_stripper cstrip_checker u_cstrip_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/cstrip_check.sv]
// cstrip_check: watches both channels of the comment stripper, predicts every
// output word from the accepted input words and compares them in order.
// depends on cstrip_pkg.
module cstrip_check
    import cstrip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        errors,
    output int        pending,
    output int        checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // scanner state of the prediction
    logic [7:0] held_byte;
    logic [7:0] last_out;
    bit         held;
    bit         held_first;
    bit         skip_held;
    bit         in_str;
    bit         in_blk;
    bit         in_line;
    bit         cont;

    out_word_t  clean_q[$];
    out_word_t  want;

    task automatic clear_scan();
        held_byte  = 8'h00;
        last_out   = 8'h00;
        held       = 1'b0;
        held_first = 1'b1;
        skip_held  = 1'b0;
        in_str     = 1'b0;
        in_blk     = 1'b0;
        in_line    = 1'b0;
        cont       = 1'b0;
    endtask

    // decide the held byte, now that its follower (if any) is known
    function automatic logic [7:0] strip_byte(input bit has_next, input logic [7:0] nxt,
                                              output bit blank_nxt);
        logic [7:0] c;
        bit         in_cmt;
        c         = skip_held ? CH_SPACE : held_byte;
        in_cmt    = in_blk || in_line;
        blank_nxt = 1'b0;
        if (c == CH_SLASH && has_next && !in_str && !in_cmt) begin
            if (nxt == CH_STAR) begin
                in_blk = 1'b1;
            end else if (nxt == CH_SLASH) begin
                in_line = 1'b1;
            end
        end else if (c == CH_QUOTE && !held_first && last_out != CH_BACKSLASH
                     && !in_cmt) begin
            in_str = !in_str;
        end else if (c == CH_STAR && has_next && nxt == CH_SLASH && in_blk && !in_line
                     && !in_str) begin
            // star-slash: both bytes come out as spaces
            in_blk    = 1'b0;
            c         = CH_SPACE;
            blank_nxt = 1'b1;
        end else if (c == CH_NEWLINE && !held_first && in_line && !cont && !in_blk
                     && !in_str) begin
            in_line = 1'b0;
        end else if (c == CH_BACKSLASH && in_line && !in_blk && !in_str) begin
            cont = 1'b1;
        end else if (c != CH_BACKSLASH && cont) begin
            cont = 1'b0;
        end
        if (in_blk || in_line) begin
            c = CH_SPACE;
        end
        last_out   = c;
        held_first = 1'b0;
        return c;
    endfunction

    task automatic take_text(input in_word_t w);
        bit         blank_nxt;
        bit         spare;
        out_word_t  o;
        blank_nxt = 1'b0;
        if (held) begin
            o.clean_byte = strip_byte(1'b1, w.text_byte, blank_nxt);
            o.clean_end  = 1'b0;
            clean_q.insert(clean_q.size(), o);
        end
        held_byte = w.text_byte;
        held      = 1'b1;
        skip_held = blank_nxt;
        // last word of the file flushes the held byte and starts over
        if (w.text_end) begin
            o.clean_byte = strip_byte(1'b0, 8'h00, spare);
            o.clean_end  = 1'b1;
            clean_q.insert(clean_q.size(), o);
            clear_scan();
        end
    endtask

    task automatic report_mismatch(input string msg);
        errors = errors + 1;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scan();
            clean_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                take_text(s_data);
            end
            if (m_valid && m_ready) begin
                if (clean_q.size() == 0) begin
                    report_mismatch($sformatf("output word %h with nothing expected",
                                              m_data));
                end else begin
                    want = clean_q.pop_front();
                    if (m_data.clean_byte !== want.clean_byte) begin
                        report_mismatch($sformatf("word %0d clean_byte %h, expected %h",
                                                  checked, m_data.clean_byte,
                                                  want.clean_byte));
                    end
                    if (m_data.clean_end !== want.clean_end) begin
                        report_mismatch($sformatf("word %0d clean_end %b, expected %b",
                                                  checked, m_data.clean_end,
                                                  want.clean_end));
                    end
                    checked = checked + 1;
                end
            end
        end
        pending <= clean_q.size();
    end

endmodule

[verif/tb_c_comment_stripper.sv]
// tb_c_comment_stripper: drives files of source text into the comment stripper
// with random idling on both channels and gives the verdict.
// depends on cstrip_pkg, c_comment_stripper and cstrip_check.
module tb_c_comment_stripper;
    import cstrip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_WORDS  = 800;
    localparam int HOLD_CYCLES = 300;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int errors;
    int pending;
    int checked;

    bit hold_req = 1'b0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;
    int words_sent = 0;
    int files_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    c_comment_stripper dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cstrip_check chk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    // mostly no gap, some short ones, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    // byte mix weighted toward the characters the scanner reacts to
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) begin
            return CH_SLASH;
        end else if (r < 24) begin
            return CH_STAR;
        end else if (r < 34) begin
            return CH_NEWLINE;
        end else if (r < 42) begin
            return CH_BACKSLASH;
        end else if (r < 52) begin
            return CH_QUOTE;
        end else if (r < 60) begin
            return CH_SPACE;
        end else if (r < 64) begin
            return 8'h27;
        end else if (r < 85) begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        s_valid <= 1'b1;
        s_data  <= '{text_byte: b, text_end: last};
        do @(posedge aclk); while (!s_ready);
        words_sent = words_sent + 1;
        if (last) begin
            files_sent = files_sent + 1;
        end
        gap = quiet_tx ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], i == s.len() - 1);
        end
    endtask

    task automatic send_file(input int len, inout int count);
        for (int i = 0; i < len; i++) begin
            send_word(pick_char(), i == len - 1);
        end
        count = count + len;
    endtask

    // s_valid must already be low; pending is registered, so step first
    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : sink
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req <= 1'b0;
            end else begin
                gap = quiet_rx ? 0 : idle_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    initial begin : stim
        int rand_words;
        int stage;
        int len;
        rand_words = 0;
        stage      = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-word files at both byte extremes
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        // slash star slash closes at once
        send_text("/*/a");
        // line comment carried on by a backslash, then closed by a newline
        send_text("//\\\nx\n");
        // a leading quote does not open a string; inside one, slash star is text
        send_text("\"\"/*");
        // escaped quote, then a character literal whose quote toggles strings
        send_text("x\\\"'\"'/");

        while (rand_words < RAND_WORDS) begin
            if (stage == 0 && rand_words >= 250) begin
                // sink stalls while words keep coming, so the block fills and stalls
                hold_req <= 1'b1;
                quiet_tx = 1'b1;
                send_file(40, rand_words);
                quiet_tx = 1'b0;
                stage    = 1;
            end else if (stage == 1 && rand_words >= 450) begin
                s_valid <= 1'b0;
                wait_drained();
                stage = 2;
            end else if (stage == 2 && rand_words >= 550) begin
                quiet_tx = 1'b1;
                quiet_rx = 1'b1;
                stage    = 3;
            end else if (stage == 3 && rand_words >= 650) begin
                quiet_tx = 1'b0;
                quiet_rx = 1'b0;
                stage    = 4;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 16);
            send_file(len, rand_words);
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("sent %0d text words in %0d files, including stalled and idle-free stretches",
                 words_sent, files_sent);
        $display("checked %0d output words", checked);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
